FILE: rtl/core/psc_pkg.sv
// Package for the parabolic sine and cosine block.
// Holds the fixed-point constants and pipeline depth used by parabolic_sine_cosine.
// Depends on nothing.
package psc_pkg;

    localparam int LATENCY = 10;

    localparam int CORR_W = 16;

    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;

    localparam logic signed [31:0] B_Q30     = 32'sd1367130551;
    localparam logic signed [31:0] C_MAG_Q30 = 32'sd435171170;

    localparam logic [CORR_W-1:0] CORR_RESET = 16'd15144;

    localparam logic signed [63:0] HALF_LSB_28 = 64'sd134217728;
    localparam logic signed [63:0] HALF_LSB_30 = 64'sd536870912;
    localparam logic signed [51:0] HALF_LSB_16 = 52'sd32768;

    localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

endpackage

FILE: rtl/core/parabolic_sine_cosine.sv
// Top level of the parabolic sine and cosine approximation pipeline.
// Depends on psc_pkg for constants and the pipeline depth.
//
// Channel   | Ports                         | Transaction when
// ----------+-------------------------------+-------------------------------
// command   | start, busy, command, angle   | start high and busy low
// result    | done, value                   | done high (one cycle, no hold)
// config    | cfg_valid, cfg_ready, cfg_data| cfg_valid and cfg_ready high
//
// One item enters every cycle and its result leaves the last stage with done.
// The pipeline has ten register stages: wrap, wrap, two multiplies,
// round, multiply, subtract, square, difference, weight multiply, sum.
// Busy stays low and the receiver cannot stall, so nothing ever waits.
// Reset clears the valid bits and loads the default correction weight.
module parabolic_sine_cosine
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        command,
    input  logic signed [31:0]          angle,
    output logic                        done,
    output logic signed [31:0]          value,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [psc_pkg::CORR_W-1:0]  cfg_data
);

    localparam int LAT = psc_pkg::LATENCY;

    logic [psc_pkg::CORR_W-1:0] p_reg, p_next;
    logic [LAT-1:0]             vld_reg, vld_next;

    logic signed [33:0] a_sum;
    logic signed [33:0] x1_reg, x1_next;
    logic signed [33:0] x_wrap;
    logic signed [31:0] x2_reg, x2_next;
    logic signed [31:0] abs_x;
    logic signed [63:0] bx_reg, bx_next;
    logic signed [63:0] xx_reg, xx_next;
    logic signed [63:0] sum_bx, sum_xx;
    logic signed [33:0] bxr4_reg, bxr4_next;
    logic signed [33:0] t_reg, t_next;
    logic signed [63:0] ct_reg, ct_next;
    logic signed [33:0] bxr5_reg, bxr5_next;
    logic signed [63:0] sum_ct;
    logic signed [33:0] ctr;
    logic signed [33:0] y_wide;
    logic signed [32:0] y6_reg, y6_next;
    logic signed [32:0] abs_y;
    logic signed [63:0] yy_reg, yy_next;
    logic signed [32:0] y7_reg, y7_next;
    logic signed [63:0] sum_yy;
    logic signed [33:0] yyr;
    logic signed [33:0] d_reg, d_next;
    logic signed [32:0] y8_reg, y8_next;
    logic signed [51:0] pd_reg, pd_next;
    logic signed [32:0] y9_reg, y9_next;
    logic signed [51:0] sum_pd;
    logic signed [35:0] pdr;
    logic signed [35:0] r_sum;
    logic signed [31:0] value_reg, value_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = vld_reg[LAT-1];
    assign value     = value_reg;

    always_comb
    begin
        p_next   = (cfg_valid && cfg_ready) ? cfg_data : p_reg;
        vld_next = {vld_reg[LAT-2:0], start && !busy};
    end

    always_comb
    begin
        a_sum = $signed({{2{angle[31]}}, angle}) + (command ? psc_pkg::HALF_PI_Q28 : 34'sd0);
        if (command && (a_sum > psc_pkg::PI_Q28))
        begin
            x1_next = a_sum - psc_pkg::TWO_PI_Q28;
        end
        else
        begin
            x1_next = a_sum;
        end
    end

    always_comb
    begin
        if (x1_reg > psc_pkg::PI_Q28)
        begin
            x_wrap = x1_reg - psc_pkg::TWO_PI_Q28;
        end
        else if (x1_reg < -psc_pkg::PI_Q28)
        begin
            x_wrap = x1_reg + psc_pkg::TWO_PI_Q28;
        end
        else
        begin
            x_wrap = x1_reg;
        end
        x2_next = x_wrap[31:0];
    end

    always_comb
    begin
        abs_x   = x2_reg[31] ? -x2_reg : x2_reg;
        bx_next = 64'(psc_pkg::B_Q30) * 64'(x2_reg);
        xx_next = 64'(x2_reg) * 64'($signed({1'b0, abs_x}));
    end

    always_comb
    begin
        sum_bx    = bx_reg + psc_pkg::HALF_LSB_28;
        sum_xx    = xx_reg + psc_pkg::HALF_LSB_28;
        bxr4_next = sum_bx[61:28];
        t_next    = sum_xx[61:28];
    end

    always_comb
    begin
        ct_next   = 64'(psc_pkg::C_MAG_Q30) * 64'(t_reg);
        bxr5_next = bxr4_reg;
    end

    always_comb
    begin
        sum_ct  = ct_reg + psc_pkg::HALF_LSB_28;
        ctr     = sum_ct[61:28];
        y_wide  = bxr5_reg - ctr;
        y6_next = y_wide[32:0];
    end

    always_comb
    begin
        abs_y   = y6_reg[32] ? -y6_reg : y6_reg;
        yy_next = 64'(y6_reg) * 64'($signed({1'b0, abs_y}));
        y7_next = y6_reg;
    end

    always_comb
    begin
        sum_yy  = yy_reg + psc_pkg::HALF_LSB_30;
        yyr     = sum_yy[63:30];
        d_next  = yyr - $signed({y7_reg[32], y7_reg});
        y8_next = y7_reg;
    end

    always_comb
    begin
        pd_next = 52'(d_reg) * 52'($signed({1'b0, p_reg}));
        y9_next = y8_reg;
    end

    always_comb
    begin
        sum_pd = pd_reg + psc_pkg::HALF_LSB_16;
        pdr    = sum_pd[51:16];
        r_sum  = $signed({{3{y9_reg[32]}}, y9_reg}) + pdr;
        if (r_sum > psc_pkg::SAT_MAX)
        begin
            value_next = psc_pkg::SAT_MAX[31:0];
        end
        else if (r_sum < psc_pkg::SAT_MIN)
        begin
            value_next = psc_pkg::SAT_MIN[31:0];
        end
        else
        begin
            value_next = r_sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg   <= psc_pkg::CORR_RESET;
            vld_reg <= '0;
        end
        else
        begin
            p_reg   <= p_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= x1_next;
        x2_reg    <= x2_next;
        bx_reg    <= bx_next;
        xx_reg    <= xx_next;
        bxr4_reg  <= bxr4_next;
        t_reg     <= t_next;
        ct_reg    <= ct_next;
        bxr5_reg  <= bxr5_next;
        y6_reg    <= y6_next;
        yy_reg    <= yy_next;
        y7_reg    <= y7_next;
        d_reg     <= d_next;
        y8_reg    <= y8_next;
        pd_reg    <= pd_next;
        y9_reg    <= y9_next;
        value_reg <= value_next;
    end

    // Every result comes from an earlier accepted transaction.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching command");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("command transaction produced no result");

    a_wrapped_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> (($signed({{2{x2_reg[31]}}, x2_reg}) >= -psc_pkg::PI_Q28)
            && ($signed({{2{x2_reg[31]}}, x2_reg}) <= psc_pkg::PI_Q28)))
        else $error("wrapped angle outside of plus or minus pi");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (p_reg == $past(cfg_data)))
        else $error("correction weight not updated by write");

endmodule

FILE: sim/tb_parabolic_sine_cosine.sv
// Self-checking testbench for parabolic_sine_cosine: directed table, then random commands
// over several correction weights, every result checked against a table value or an in-bench Q2.30 predictor.
// Depends on psc_pkg and the parabolic_sine_cosine RTL.
module tb_parabolic_sine_cosine;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ANGLE_PI      = 843314857;
    localparam longint ANGLE_TWO_PI  = 1686629713;
    localparam longint ANGLE_HALF_PI = 421657428;
    localparam longint SLOPE_B       = 1367130551;
    localparam longint CURVE_C_MAG   = 435171170;
    localparam int     WEIGHT_RESET  = 15144;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     ITEMS_PER_SET = 100;
    localparam int     NUM_SETS      = 5;
    localparam int     NUM_DIRECTED  = 20;

    typedef enum logic {
        FUNC_SINE   = 1'b0,
        FUNC_COSINE = 1'b1
    } func_e;

    typedef struct {
        func_e              func;
        logic signed [31:0] angle;
        bit                 known;
        logic signed [31:0] result;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       command = FUNC_SINE;
    logic signed [31:0]         angle = '0;
    logic                       done;
    logic signed [31:0]         value;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [psc_pkg::CORR_W-1:0] cfg_data = '0;

    bit                         item_known = 1'b0;
    logic signed [31:0]         item_result = '0;

    logic signed [31:0]         expected_values[$];
    logic [15:0]                active_weight = 16'(WEIGHT_RESET);
    int                         err_count = 0;
    int                         results_checked = 0;
    int                         weights_written = 0;
    int                         cycle_count = 0;
    stim_row_t                  directed_rows[NUM_DIRECTED];

    parabolic_sine_cosine i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .angle     (angle),
        .done      (done),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint round_down_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] approx_sine_cosine(input func_e func,
                                                               input logic signed [31:0] ang,
                                                               input logic [15:0] weight);
        longint x;
        longint y;
        longint t;
        longint d;
        longint r;
        x = longint'(ang);
        if (func == FUNC_COSINE)
        begin
            x += ANGLE_HALF_PI;
            if (x > ANGLE_PI)
                x -= ANGLE_TWO_PI;
        end
        if (x > ANGLE_PI)
            x -= ANGLE_TWO_PI;
        if (x < -ANGLE_PI)
            x += ANGLE_TWO_PI;
        y = round_down_shift(SLOPE_B * x, 28);
        t = round_down_shift(x * ((x < 0) ? -x : x), 28);
        y -= round_down_shift(CURVE_C_MAG * t, 28);
        d = round_down_shift(y * ((y < 0) ? -y : y), 30) - y;
        r = y + round_down_shift(d * longint'({48'd0, weight}), 16);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("value: no transaction expected, actual %0d", value);
                    err_count++;
                end
                else if (value !== expected_values[0])
                begin
                    $error("value: expected %0d, actual %0d", expected_values[0], value);
                    err_count++;
                    void'(expected_values.pop_front());
                end
                else
                begin
                    void'(expected_values.pop_front());
                end
                results_checked++;
            end
            if (start && !busy)
                expected_values.push_back(item_known ? item_result :
                    approx_sine_cosine(func_e'(command), angle, active_weight));
            if (cfg_valid && cfg_ready)
            begin
                active_weight = cfg_data;
                weights_written++;
            end
        end
    end

    task automatic send_command(input func_e func, input logic signed [31:0] ang,
                                input bit known, input logic signed [31:0] result);
        @(negedge clk);
        start       <= 1'b1;
        command     <= func;
        angle       <= ang;
        item_known  <= known;
        item_result <= result;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_values.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_weight(input logic [15:0] weight);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= weight;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0]        set_weights[NUM_SETS];
        logic signed [31:0] rand_angle;
        func_e              rand_func;
        longint             offs;
        bit                 allow_idle;

        directed_rows = '{
            '{FUNC_SINE,   32'sd0,            1'b1, 32'sd0},
            '{FUNC_COSINE, -32'sd421657428,   1'b1, 32'sd0},
            '{FUNC_SINE,   32'sd843314857,    1'b0, 32'sd0},
            '{FUNC_SINE,   -32'sd843314857,   1'b0, 32'sd0},
            '{FUNC_SINE,   32'sd843314858,    1'b0, 32'sd0},
            '{FUNC_SINE,   -32'sd843314858,   1'b0, 32'sd0},
            '{FUNC_SINE,   32'h7FFF_FFFF,     1'b0, 32'sd0},
            '{FUNC_SINE,   32'h8000_0000,     1'b0, 32'sd0},
            '{FUNC_COSINE, 32'h7FFF_FFFF,     1'b0, 32'sd0},
            '{FUNC_COSINE, 32'h8000_0000,     1'b0, 32'sd0},
            '{FUNC_COSINE, 32'sd421657429,    1'b0, 32'sd0},
            '{FUNC_COSINE, 32'sd421657430,    1'b0, 32'sd0},
            '{FUNC_SINE,   32'sd421657428,    1'b0, 32'sd0},
            '{FUNC_SINE,   -32'sd421657428,   1'b0, 32'sd0},
            '{FUNC_COSINE, 32'sd0,            1'b0, 32'sd0},
            '{FUNC_SINE,   32'sd1,            1'b0, 32'sd0},
            '{FUNC_SINE,   -32'sd1,           1'b0, 32'sd0},
            '{FUNC_COSINE, -32'sd1264972286,  1'b0, 32'sd0},
            '{FUNC_SINE,   32'h5555_5555,     1'b0, 32'sd0},
            '{FUNC_COSINE, 32'hAAAA_AAAA,     1'b0, 32'sd0}
        };
        set_weights = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                        16'($urandom_range(0, 65535))};

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if ($urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 10));
            send_command(directed_rows[i].func, directed_rows[i].angle,
                         directed_rows[i].known, directed_rows[i].result);
        end
        wait_drained();

        for (int set = 0; set < NUM_SETS; set++)
        begin
            write_weight(set_weights[set]);
            allow_idle = (set != NUM_SETS - 1);
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                if (allow_idle && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 10));
                rand_func = func_e'($urandom_range(0, 1));
                offs = longint'($urandom_range(0, 6)) - 3;
                case ($urandom_range(0, 7))
                    0: rand_angle = 32'((($urandom_range(0, 1) != 0) ?
                                         ANGLE_PI : -ANGLE_PI) + offs);
                    1:
                    begin
                        rand_func  = FUNC_COSINE;
                        rand_angle = 32'((($urandom_range(0, 1) != 0) ?
                                          ANGLE_PI - ANGLE_HALF_PI :
                                          -ANGLE_PI - ANGLE_HALF_PI) + offs);
                    end
                    default: rand_angle = $urandom;
                endcase
                send_command(rand_func, rand_angle, 1'b0, 32'sd0);
            end
            wait_drained();
        end

        repeat (psc_pkg::LATENCY + 4) @(negedge clk);
        $display("Checked %0d results: %0d directed commands, then %0d random ones",
                 results_checked, NUM_DIRECTED, NUM_SETS * ITEMS_PER_SET);
        $display("under %0d correction weight writes including 0x0000 and 0xFFFF.",
                 weights_written);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
